### hw/rtl/tpm_x4_pkg.sv
// Package: shared constants, types and filter coefficients of the 4x true-peak meter.
`timescale 1ns / 1ps
package tpm_x4_pkg;

  localparam int CHANNELS     = 8;
  localparam int CH_W         = 3;
  localparam int TAPS         = 12;
  localparam int HIST         = TAPS - 1;
  localparam int PHASES       = 4;
  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_W       = 18;
  localparam int SUM_W        = SAMPLE_BITS + COEF_W + 1;
  localparam int RESULT_SHIFT = 16;
  localparam int PEAK_W       = 25;
  localparam int MAG_W        = SUM_W - RESULT_SHIFT;
  localparam int IN_DATA_W    = 24;
  localparam int IN_USER_W    = 5;
  localparam int OUT_DATA_W   = 56;
  localparam int OUT_USER_W   = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [HIST-1:0]            hist_t;
  typedef logic [PEAK_W-1:0]             peak_t;
  typedef logic [CH_W-1:0]               chan_t;
  typedef logic signed [COEF_W-1:0]      coef_t;

  // Phase 0 and phase 1 in Q1.16; phases 2 and 3 are these two reversed.
  localparam int COEF_A [TAPS] = '{
    112, 720, -1288, 2176, -3896, 9000,
    63712, -6704, 3120, -1744, 976, -544
  };
  localparam int COEF_B [TAPS] = '{
    -1912, 1920, -3392, 5840, -10912, 30480,
    51104, -13128, 6656, -3816, 2168, -1240
  };

  function automatic coef_t coef_of(input int phase, input int j);
    coef_t c;
    case (phase)
      0:       c = COEF_W'(COEF_A[j]);
      1:       c = COEF_W'(COEF_B[j]);
      2:       c = COEF_W'(COEF_B[TAPS-1-j]);
      default: c = COEF_W'(COEF_A[TAPS-1-j]);
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/true_peak_meter_x4_top.sv
// Top level of the 4x oversampling true-peak meter with per-channel and overall peaks.
`timescale 1ns / 1ps
// Usage: one audio sample enters per item on the slave stream, with its channel and two
// flags in tuser. Clear-history zeroes every channel's delay line and block-start clears
// every peak, both before the sample is filtered. Each item yields exactly one result
// on the master stream: the channel, that channel's running true peak and the overall
// running true peak, both unsigned Q2.23.
// An accepted item sits in an input register; the filter, history and peak updates then
// happen in a single pass into the result register, loaded as the item leaves the input
// register. One item is taken every cycle unless the receiver stalls, set by that single
// pass: the history and peaks written by one item are read by the next.
// Reset clears all delay lines, all peaks and both stages. When the receiver stalls the
// result is held, one further item waits in the input register, and tready falls only
// once both stages are full.
module true_peak_meter_x4_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // sample [23:0]
  input  logic [tpm_x4_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // channel [2:0], start_block [3], clear_history [4]
  input  logic [tpm_x4_pkg::IN_USER_W-1:0]    s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // channel_peak [24:0], overall_peak [49:25], zero [55:50]
  output logic [tpm_x4_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // channel_out [2:0]
  output logic [tpm_x4_pkg::OUT_USER_W-1:0]   m_axis_tuser_o
);
  import tpm_x4_pkg::*;

  logic    in_valid_q;
  chan_t   chan_q;
  sample_t sample_q;
  logic    start_q;
  logic    clrh_q;

  logic    out_valid_q;
  chan_t   out_chan_q;
  peak_t   out_ch_peak_q;
  peak_t   out_all_peak_q;

  hist_t   hist_q     [CHANNELS];
  peak_t   peak_ch_q  [CHANNELS];
  peak_t   peak_all_q;

  logic    advance;
  logic    in_take;
  hist_t   row_eff;
  hist_t   row_d;
  peak_t   mag;
  peak_t   old_ch;
  peak_t   old_all;
  peak_t   new_ch;
  peak_t   new_all;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  assign row_eff = clrh_q ? '0 : hist_q[chan_q];
  assign row_d   = {row_eff[HIST-2:0], sample_q};
  assign old_ch  = start_q ? '0 : peak_ch_q[chan_q];
  assign old_all = start_q ? '0 : peak_all_q;
  assign new_ch  = (mag > old_ch)  ? mag : old_ch;
  assign new_all = (mag > old_all) ? mag : old_all;

  tpm_x4_fir u_fir (
    .cur_i  (sample_q),
    .hist_i (row_eff),
    .mag_o  (mag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= s_axis_tdata_i[SAMPLE_BITS-1:0];
      chan_q   <= s_axis_tuser_i[CH_W-1:0];
      start_q  <= s_axis_tuser_i[CH_W];
      clrh_q   <= s_axis_tuser_i[CH_W+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        hist_q[c]    <= '0;
        peak_ch_q[c] <= '0;
      end
      peak_all_q <= '0;
    end else if (advance) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (clrh_q && (c != int'(chan_q))) begin
          hist_q[c] <= '0;
        end
        if (start_q && (c != int'(chan_q))) begin
          peak_ch_q[c] <= '0;
        end
      end
      hist_q[chan_q]    <= row_d;
      peak_ch_q[chan_q] <= new_ch;
      peak_all_q        <= new_all;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_chan_q     <= chan_q;
      out_ch_peak_q  <= new_ch;
      out_all_peak_q <= new_all;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - 2 * PEAK_W)'(0), out_all_peak_q, out_ch_peak_q};
  assign m_axis_tuser_o  = out_chan_q;

  a_all_above_ch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> peak_all_q >= peak_ch_q[$past(chan_q)])
    else $error("overall peak fell below the channel peak");

  a_out_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_all_peak_q >= out_ch_peak_q)
    else $error("reported overall peak below reported channel peak");

  a_start_peaks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && start_q |=> out_all_peak_q == out_ch_peak_q)
    else $error("block start did not leave overall peak equal to the channel peak");

  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(sample_q) && $stable(chan_q))
    else $error("waiting item lost from the input register");

endmodule

### hw/rtl/tpm_x4_fir.sv
// Four-phase polyphase interpolator returning the largest truncated magnitude.
`timescale 1ns / 1ps
module tpm_x4_fir (
  input  tpm_x4_pkg::sample_t cur_i,
  input  tpm_x4_pkg::hist_t   hist_i,
  output tpm_x4_pkg::peak_t   mag_o
);
  import tpm_x4_pkg::*;

  sample_t                  taps  [TAPS];
  logic signed [SUM_W-1:0]  acc   [PHASES];
  logic        [SUM_W-1:0]  mabs  [PHASES];
  logic        [MAG_W-1:0]  msh   [PHASES];
  peak_t                    mph   [PHASES];
  peak_t                    mmax;

  always_comb begin
    taps[0] = cur_i;
    for (int j = 1; j < TAPS; j++) begin
      taps[j] = hist_i[j-1];
    end
  end

  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      acc[p] = '0;
      for (int j = 0; j < TAPS; j++) begin
        acc[p] = acc[p] + SUM_W'($signed(taps[j])) * SUM_W'(coef_of(p, j));
      end
    end
  end

  // Magnitude is taken before the shift, so the result is the floor of |sum| / 2^RESULT_SHIFT.
  always_comb begin
    mmax = '0;
    for (int p = 0; p < PHASES; p++) begin
      mabs[p] = acc[p][SUM_W-1] ? SUM_W'(-acc[p]) : SUM_W'(acc[p]);
      msh[p]  = mabs[p][SUM_W-1:RESULT_SHIFT];
      mph[p]  = (|msh[p][MAG_W-1:PEAK_W]) ? {PEAK_W{1'b1}} : msh[p][PEAK_W-1:0];
      if (mph[p] > mmax) begin
        mmax = mph[p];
      end
    end
  end

  assign mag_o = mmax;

endmodule
